/* sv/wvm_pkg.sv */
// Package for the word VM step block: opcodes, operand codes, event kinds, FSM states.
// No dependencies.
package wvm_pkg;
	localparam logic [31:0] OP_HALT  = 32'h10000000;
	localparam logic [31:0] OP_RESET = 32'h10000001;
	localparam logic [31:0] OP_MOVE  = 32'h10000003;
	localparam logic [31:0] OP_PUSH  = 32'h10000004;
	localparam logic [31:0] OP_POP   = 32'h10000005;
	localparam logic [31:0] OP_ADD   = 32'h10000006;
	localparam logic [31:0] OP_SUB   = 32'h10000007;
	localparam logic [31:0] OP_MUL   = 32'h10000008;
	localparam logic [31:0] OP_DIV   = 32'h10000009;
	localparam logic [31:0] OP_PHEX  = 32'h1000000A;
	localparam logic [31:0] OP_PCHR  = 32'h1000000B;
	localparam logic [31:0] OP_SLEEP = 32'h1000000C;
	localparam logic [31:0] OP_JMP   = 32'h1000000E;
	localparam logic [31:0] OP_JEQ   = 32'h1000000F;
	localparam logic [31:0] OP_JNE   = 32'h10000010;
	localparam logic [31:0] OP_JGT   = 32'h10000011;
	localparam logic [31:0] OP_JLT   = 32'h10000012;
	localparam logic [31:0] OP_JGE   = 32'h10000013;
	localparam logic [31:0] OP_JLE   = 32'h10000014;
	localparam logic [31:0] RC_A  = 32'h20000001;
	localparam logic [31:0] RC_B  = 32'h20000002;
	localparam logic [31:0] RC_C  = 32'h20000003;
	localparam logic [31:0] RC_R  = 32'h20000004;
	localparam logic [31:0] RC_RI = 32'h20000005;
	localparam logic [15:0] SP_RESET = 16'd100;
	localparam logic [2:0] EV_NONE  = 3'd0;
	localparam logic [2:0] EV_HEX   = 3'd1;
	localparam logic [2:0] EV_CHAR  = 3'd2;
	localparam logic [2:0] EV_SLEEP = 3'd3;
	localparam logic [2:0] EV_HALT  = 3'd4;
	localparam logic [2:0] EV_DIVZ  = 3'd5;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_RD4,
		ST_EXEC, ST_POPRD, ST_POPWB, ST_DIV, ST_OUT
	} state_t;

	// Leading nonzero hex digit of w is 2
	function automatic logic is_regref(input logic [31:0] w);
		logic r;
		logic found;
		r = 1'b0;
		found = 1'b0;
		for (int i = 7; i >= 0; i--) begin
			if (!found && w[i*4 +: 4] != 4'h0) begin
				found = 1'b1;
				r = (w[i*4 +: 4] == 4'h2);
			end
		end
		return r;
	endfunction
endpackage

/* sv/word_vm_instruction_step_top.sv */
// Word VM step block: sequential, one command in flight at a time. Depends on wvm_pkg, wvm_div.
// An execute step reads four words through the memory read port; a pop adds a stack read
// and a write-back state, and a divide waits on the bit-serial divider.
// A new command is taken only in idle, once the previous result has been transferred.
// Reset: arst_n clears registers (SP to 100) and starts a sweep that zeroes the memory one
// word a cycle over all min(MEM_WORDS, 65536) words, with in_stall held high throughout.
module word_vm_instruction_step_top #(
	parameter int MEM_WORDS = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [15:0] load_address,
	input  logic [31:0] load_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_kind,
	output logic [31:0] event_value,
	output logic [15:0] next_pc,
	output logic        is_halted
);
	localparam int ASPACE = (MEM_WORDS < 65536) ? MEM_WORDS : 65536;
	localparam int AW = $clog2(ASPACE);

	wvm_pkg::state_t state_q, state_d;

	// Synchronous program memory with one write port and one read port
	logic [31:0] mem [ASPACE];
	logic [31:0] rdata;
	logic [AW-1:0] raddr, waddr;
	logic [31:0] wdata;
	logic we;
	logic [AW:0] clr_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

	// Architectural state
	logic [31:0] a_q, b_q, c_q, r_q, ri_q;
	logic [15:0] sp_q, pc_q;
	logic stop_q;
	// Fetched words
	logic [31:0] op_q, w1_q, w2_q, w3_q;
	// Result
	logic [2:0] kind_q;
	logic [31:0] val_q;

	logic [31:0] x, y, z;
	logic div_busy, div_start;
	logic [31:0] quo;

	function automatic logic [31:0] opval(input logic [31:0] w, input logic [31:0] a,
		input logic [31:0] b, input logic [31:0] c, input logic [31:0] r,
		input logic [31:0] ri);
		logic [31:0] v;
		v = w;
		if (wvm_pkg::is_regref(w)) begin
			unique case (w)
				wvm_pkg::RC_A:  v = a;
				wvm_pkg::RC_B:  v = b;
				wvm_pkg::RC_C:  v = c;
				wvm_pkg::RC_R:  v = r;
				wvm_pkg::RC_RI: v = ri;
				default:        v = '0;
			endcase
		end
		return v;
	endfunction

	// Widen a wrapped memory address to the 16-bit PC
	function automatic logic [15:0] pc16(input logic [AW-1:0] a);
		return 16'(a);
	endfunction

	assign x = opval(w1_q, a_q, b_q, c_q, r_q, ri_q);
	assign y = opval(w2_q, a_q, b_q, c_q, r_q, ri_q);
	assign z = opval(w3_q, a_q, b_q, c_q, r_q, ri_q);

	logic [AW-1:0] pc_a;
	assign pc_a = pc_q[AW-1:0];

	wvm_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(x), .divisor(y),
		.busy(div_busy), .quotient(quo)
	);

	logic in_xfer;
	assign in_xfer = in_valid && !in_stall;
	assign in_stall = (state_q != wvm_pkg::ST_IDLE);
	assign out_valid = (state_q == wvm_pkg::ST_OUT);
	assign event_kind = kind_q;
	assign event_value = val_q;
	assign next_pc = pc_q;
	assign is_halted = stop_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wvm_pkg::ST_CLEAR: if (clr_q == (AW+1)'(ASPACE - 1)) state_d = wvm_pkg::ST_IDLE;
			wvm_pkg::ST_IDLE: begin
				if (in_xfer)
					state_d = (command && !stop_q) ? wvm_pkg::ST_RD0 : wvm_pkg::ST_OUT;
			end
			wvm_pkg::ST_RD0: state_d = wvm_pkg::ST_RD1;
			wvm_pkg::ST_RD1: state_d = wvm_pkg::ST_RD2;
			wvm_pkg::ST_RD2: state_d = wvm_pkg::ST_RD3;
			wvm_pkg::ST_RD3: state_d = wvm_pkg::ST_RD4;
			wvm_pkg::ST_RD4: state_d = wvm_pkg::ST_EXEC;
			wvm_pkg::ST_EXEC: begin
				if (op_q == wvm_pkg::OP_POP) state_d = wvm_pkg::ST_POPRD;
				else if (op_q == wvm_pkg::OP_DIV && y != '0) state_d = wvm_pkg::ST_DIV;
				else state_d = wvm_pkg::ST_OUT;
			end
			wvm_pkg::ST_POPRD: state_d = wvm_pkg::ST_POPWB;
			wvm_pkg::ST_POPWB: state_d = wvm_pkg::ST_OUT;
			wvm_pkg::ST_DIV: if (!div_busy && !div_start) state_d = wvm_pkg::ST_OUT;
			wvm_pkg::ST_OUT: if (!out_stall) state_d = wvm_pkg::ST_IDLE;
			default: state_d = wvm_pkg::ST_IDLE;
		endcase
	end

	// Memory port control and divider start
	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = pc_a;
		div_start = 1'b0;
		unique case (state_q)
			wvm_pkg::ST_CLEAR: begin
				we = 1'b1;
				waddr = clr_q[AW-1:0];
			end
			wvm_pkg::ST_IDLE: begin
				we = in_xfer && !command;
				waddr = load_address[AW-1:0];
				wdata = load_word;
			end
			wvm_pkg::ST_RD0: raddr = pc_a;
			wvm_pkg::ST_RD1: raddr = pc_a + AW'(1);
			wvm_pkg::ST_RD2: raddr = pc_a + AW'(2);
			wvm_pkg::ST_RD3: raddr = pc_a + AW'(3);
			wvm_pkg::ST_EXEC: begin
				we = (op_q == wvm_pkg::OP_PUSH);
				waddr = sp_q[AW-1:0];
				wdata = x;
				raddr = sp_q[AW-1:0] - AW'(1);
				div_start = (op_q == wvm_pkg::OP_DIV) && (y != '0);
			end
			// Hold the stack read address, SP is already decremented
			wvm_pkg::ST_POPRD: raddr = sp_q[AW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wvm_pkg::ST_CLEAR;
			clr_q <= '0;
			a_q <= '0; b_q <= '0; c_q <= '0; r_q <= '0; ri_q <= '0;
			sp_q <= wvm_pkg::SP_RESET;
			pc_q <= '0;
			stop_q <= 1'b0;
			kind_q <= wvm_pkg::EV_NONE;
			val_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == wvm_pkg::ST_CLEAR)
				clr_q <= clr_q + (AW+1)'(1);
			if (in_xfer) begin
				kind_q <= wvm_pkg::EV_NONE;
				val_q <= '0;
			end
			if (state_q == wvm_pkg::ST_POPWB)
				r_q <= rdata;
			if (state_q == wvm_pkg::ST_DIV && !div_busy) begin
				r_q <= quo;
				pc_q <= pc16(pc_a + AW'(3));
			end
			if (state_q == wvm_pkg::ST_EXEC) begin
				pc_q <= pc16(pc_a + AW'(1));
				unique case (op_q)
					wvm_pkg::OP_HALT: begin
						stop_q <= 1'b1;
						kind_q <= wvm_pkg::EV_HALT;
						pc_q <= pc_q;
					end
					wvm_pkg::OP_RESET: begin
						a_q <= '0; b_q <= '0; c_q <= '0; r_q <= '0;
						sp_q <= wvm_pkg::SP_RESET;
						pc_q <= '0;
					end
					wvm_pkg::OP_MOVE: begin
						unique case (w2_q)
							wvm_pkg::RC_A:  a_q <= x;
							wvm_pkg::RC_B:  b_q <= x;
							wvm_pkg::RC_C:  c_q <= x;
							wvm_pkg::RC_R:  r_q <= x;
							wvm_pkg::RC_RI: ri_q <= x;
							default: ;
						endcase
						pc_q <= pc16(pc_a + AW'(3));
					end
					wvm_pkg::OP_PUSH: begin
						sp_q <= sp_q + 16'd1;
						pc_q <= pc16(pc_a + AW'(2));
					end
					wvm_pkg::OP_POP: begin
						sp_q <= sp_q - 16'd1;
						pc_q <= pc16(pc_a + AW'(2));
					end
					wvm_pkg::OP_ADD: begin r_q <= x + y; pc_q <= pc16(pc_a + AW'(3)); end
					wvm_pkg::OP_SUB: begin r_q <= x - y; pc_q <= pc16(pc_a + AW'(3)); end
					wvm_pkg::OP_MUL: begin r_q <= x * y; pc_q <= pc16(pc_a + AW'(3)); end
					wvm_pkg::OP_DIV: begin
						// Divide by zero stops; nonzero divisor waits on the divider
						pc_q <= pc_q;
						if (y == '0) begin
							stop_q <= 1'b1;
							kind_q <= wvm_pkg::EV_DIVZ;
						end
					end
					wvm_pkg::OP_PHEX: begin
						kind_q <= wvm_pkg::EV_HEX; val_q <= x;
						pc_q <= pc16(pc_a + AW'(2));
					end
					wvm_pkg::OP_PCHR: begin
						kind_q <= wvm_pkg::EV_CHAR; val_q <= {24'd0, x[7:0]};
						pc_q <= pc16(pc_a + AW'(2));
					end
					wvm_pkg::OP_SLEEP: begin
						kind_q <= wvm_pkg::EV_SLEEP; val_q <= w1_q;
						pc_q <= pc16(pc_a + AW'(2));
					end
					wvm_pkg::OP_JMP: pc_q <= pc16(x[AW-1:0] + AW'(1));
					wvm_pkg::OP_JEQ, wvm_pkg::OP_JNE, wvm_pkg::OP_JGT,
					wvm_pkg::OP_JLT, wvm_pkg::OP_JGE, wvm_pkg::OP_JLE: begin
						if ((op_q == wvm_pkg::OP_JEQ && x == y) ||
							(op_q == wvm_pkg::OP_JNE && x != y) ||
							(op_q == wvm_pkg::OP_JGT && x > y) ||
							(op_q == wvm_pkg::OP_JLT && x < y) ||
							(op_q == wvm_pkg::OP_JGE && x >= y) ||
							(op_q == wvm_pkg::OP_JLE && x <= y))
							pc_q <= pc16(z[AW-1:0] + AW'(1));
						else
							pc_q <= pc16(pc_a + AW'(4));
					end
					default: ;
				endcase
			end
		end
	end

	// Capture each fetched word in the cycle after its read address
	always_ff @(posedge clk) begin
		if (state_q == wvm_pkg::ST_RD1) op_q <= rdata;
		if (state_q == wvm_pkg::ST_RD2) w1_q <= rdata;
		if (state_q == wvm_pkg::ST_RD3) w2_q <= rdata;
		if (state_q == wvm_pkg::ST_RD4) w3_q <= rdata;
	end

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |-> state_q == wvm_pkg::ST_IDLE) else $error("accept while busy");
	a_halt_stays: assert property (@(posedge clk) disable iff (!arst_n)
		$past(stop_q) && state_q != wvm_pkg::ST_CLEAR |-> stop_q)
		else $error("stopped cleared");
	a_halt_pc: assert property (@(posedge clk) disable iff (!arst_n)
		stop_q && state_q == wvm_pkg::ST_IDLE |=> $stable(pc_q))
		else $error("pc moved while stopped");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wvm_pkg::ST_OUT |-> !div_busy) else $error("divider busy at result");
`endif
endmodule

/* sv/wvm_div.sv */
// Radix-2 restoring unsigned divider that forms the quotient bit-serially.
// Depends on nothing.
module wvm_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [31:0] quotient
);
	logic [31:0] rem_q, quo_q, dvs_q;
	logic [5:0]  cnt_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};
	assign busy = (cnt_q != 6'd0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end
endmodule

/* test/vm_step_checker.sv */
// Checker for the word VM step block: predicts every result and compares transfers.
// Depends on wvm_pkg.
`timescale 1ns / 100ps
module vm_step_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        command,
	input  logic [15:0] load_address,
	input  logic [31:0] load_word,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  event_kind,
	input  logic [31:0] event_value,
	input  logic [15:0] next_pc,
	input  logic        is_halted,
	output int          failures
);
	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] value;
		logic [15:0] pc;
		logic        halted;
	} step_result_t;

	logic [31:0] vm_mem [0:65535];
	logic [31:0] ra, rb, rc, rr, rri;
	logic [15:0] sp, pc;
	logic        stopped;
	step_result_t pending_q[$];
	step_result_t want, made;
	int mismatches;

	initial begin
		for (int i = 0; i < 65536; i++)
			vm_mem[i] = '0;
		ra = '0; rb = '0; rc = '0; rr = '0; rri = '0;
		sp = wvm_pkg::SP_RESET;
		pc = '0;
		stopped = 1'b0;
		mismatches = 0;
	end

	// A word whose leading hex digit is 2 names a register, else it is an immediate
	function automatic logic [31:0] src_value(input logic [31:0] w);
		logic [31:0] lead;
		lead = w;
		while (lead > 32'hF)
			lead = lead >> 4;
		if (lead != 32'h2)
			return w;
		case (w)
			wvm_pkg::RC_A:  return ra;
			wvm_pkg::RC_B:  return rb;
			wvm_pkg::RC_C:  return rc;
			wvm_pkg::RC_R:  return rr;
			wvm_pkg::RC_RI: return rri;
			default:        return '0;
		endcase
	endfunction

	task automatic dest_write(input logic [31:0] code, input logic [31:0] v);
		case (code)
			wvm_pkg::RC_A:  ra = v;
			wvm_pkg::RC_B:  rb = v;
			wvm_pkg::RC_C:  rc = v;
			wvm_pkg::RC_R:  rr = v;
			wvm_pkg::RC_RI: rri = v;
			default: ;
		endcase
	endtask

	task automatic run_command(input logic cmd, input logic [15:0] addr,
			input logic [31:0] word, output step_result_t res);
		logic [31:0] op, w1, w2, w3, x, y, z;
		logic [15:0] nxt;
		logic taken;
		res = '0;
		nxt = pc;
		if (!cmd) begin
			vm_mem[addr] = word;
		end else if (!stopped) begin
			op = vm_mem[pc];
			w1 = vm_mem[pc + 16'd1];
			w2 = vm_mem[pc + 16'd2];
			w3 = vm_mem[pc + 16'd3];
			x = src_value(w1);
			y = src_value(w2);
			z = src_value(w3);
			nxt = pc + 16'd1;
			case (op)
				wvm_pkg::OP_HALT: begin
					stopped = 1'b1;
					res.kind = wvm_pkg::EV_HALT;
					nxt = pc;
				end
				wvm_pkg::OP_RESET: begin
					ra = '0; rb = '0; rc = '0; rr = '0;
					sp = wvm_pkg::SP_RESET;
					nxt = '0;
				end
				wvm_pkg::OP_MOVE: begin
					dest_write(w2, x);
					nxt = pc + 16'd3;
				end
				wvm_pkg::OP_PUSH: begin
					vm_mem[sp] = x;
					sp = sp + 16'd1;
					nxt = pc + 16'd2;
				end
				wvm_pkg::OP_POP: begin
					sp = sp - 16'd1;
					rr = vm_mem[sp];
					nxt = pc + 16'd2;
				end
				wvm_pkg::OP_ADD: begin rr = x + y; nxt = pc + 16'd3; end
				wvm_pkg::OP_SUB: begin rr = x - y; nxt = pc + 16'd3; end
				wvm_pkg::OP_MUL: begin rr = x * y; nxt = pc + 16'd3; end
				wvm_pkg::OP_DIV: begin
					if (y == '0) begin
						stopped = 1'b1;
						res.kind = wvm_pkg::EV_DIVZ;
						nxt = pc;
					end else begin
						rr = x / y;
						nxt = pc + 16'd3;
					end
				end
				wvm_pkg::OP_PHEX: begin
					res.kind = wvm_pkg::EV_HEX;
					res.value = x;
					nxt = pc + 16'd2;
				end
				wvm_pkg::OP_PCHR: begin
					res.kind = wvm_pkg::EV_CHAR;
					res.value = {24'h0, x[7:0]};
					nxt = pc + 16'd2;
				end
				wvm_pkg::OP_SLEEP: begin
					res.kind = wvm_pkg::EV_SLEEP;
					res.value = w1;
					nxt = pc + 16'd2;
				end
				wvm_pkg::OP_JMP: nxt = x[15:0] + 16'd1;
				wvm_pkg::OP_JEQ, wvm_pkg::OP_JNE, wvm_pkg::OP_JGT,
				wvm_pkg::OP_JLT, wvm_pkg::OP_JGE, wvm_pkg::OP_JLE: begin
					case (op)
						wvm_pkg::OP_JEQ: taken = (x == y);
						wvm_pkg::OP_JNE: taken = (x != y);
						wvm_pkg::OP_JGT: taken = (x > y);
						wvm_pkg::OP_JLT: taken = (x < y);
						wvm_pkg::OP_JGE: taken = (x >= y);
						default:         taken = (x <= y);
					endcase
					nxt = taken ? z[15:0] + 16'd1 : pc + 16'd4;
				end
				default: ;
			endcase
			pc = nxt;
		end
		res.pc = nxt;
		res.halted = stopped;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_q.size() == 0) begin
					$error("result transfer with nothing pending: kind %0h value %0h pc %0h",
						event_kind, event_value, next_pc);
					mismatches++;
				end else begin
					want = pending_q.pop_front();
					if (event_kind !== want.kind) begin
						$error("event_kind expected %0h got %0h", want.kind, event_kind);
						mismatches++;
					end
					if (event_value !== want.value) begin
						$error("event_value expected %0h got %0h", want.value, event_value);
						mismatches++;
					end
					if (next_pc !== want.pc) begin
						$error("next_pc expected %0h got %0h", want.pc, next_pc);
						mismatches++;
					end
					if (is_halted !== want.halted) begin
						$error("is_halted expected %0h got %0h", want.halted, is_halted);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				run_command(command, load_address, load_word, made);
				pending_q.push_back(made);
			end
			failures <= mismatches + pending_q.size();
		end
	end
endmodule

/* test/word_vm_instruction_step_top_test.sv */
// Testbench top for the word VM step block: builds small programs, steps them, gives the verdict.
// Depends on wvm_pkg, word_vm_instruction_step_top and vm_step_checker.
`timescale 1ns / 100ps
module word_vm_instruction_step_top_test;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int TARGET_ITEMS = 950;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        command;
	logic [15:0] load_address;
	logic [31:0] load_word;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  event_kind;
	logic [31:0] event_value;
	logic [15:0] next_pc;
	logic        is_halted;
	int          failures;

	int          sent, burst_left, writes_done, steps_done;
	int          got = 0;
	int          cycles = 0;
	logic [15:0] last_pc = '0;
	bit          hold_req, hold_taken, ended_on_halt;

	// Program under construction, the offsets where instructions start, and jump
	// operand slots still waiting for a target
	logic [31:0] prog[$];
	int          starts[$];
	int          jump_slots[$];

	word_vm_instruction_step_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .load_address(load_address), .load_word(load_word),
		.out_valid(out_valid), .out_stall(out_stall),
		.event_kind(event_kind), .event_value(event_value),
		.next_pc(next_pc), .is_halted(is_halted)
	);

	vm_step_checker scoreboard (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .load_address(load_address), .load_word(load_word),
		.out_valid(out_valid), .out_stall(out_stall),
		.event_kind(event_kind), .event_value(event_value),
		.next_pc(next_pc), .is_halted(is_halted),
		.failures(failures)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Track result transfers so the sender can tell when the block has drained,
	// and where the program counter ended up
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got <= got + 1;
			last_pc <= next_pc;
		end
	end

	// Give up on a hung block
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("word_vm_instruction_step_top_test: done, errors");
			$finish;
		end
	end

	// Receiver: stall on its own pattern, in random modes that it switches between.
	// Once asked, hold off for a long stretch so the block backs up into its input.
	initial begin
		int mode;
		int left;
		mode = 0;
		left = 0;
		out_stall = 1'b0;
		forever begin
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 100);
			end
			left--;
			case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 1) == 1);
				default: out_stall <= ($urandom_range(0, 9) != 0);
			endcase
			@(posedge clk);
		end
	end

	// Offer one command and hold it until the block takes it. Between bursts,
	// drop valid for a random gap.
	task automatic send_cmd(input logic cmd, input logic [15:0] addr, input logic [31:0] word);
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 10);
		end
		in_valid <= 1'b1;
		command <= cmd;
		load_address <= addr;
		load_word <= word;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
		burst_left--;
		if (cmd)
			steps_done++;
		else
			writes_done++;
	endtask

	// Wait until every transfer sent has produced its result
	task automatic drain();
		while (got != sent)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic run_steps(input int n);
		repeat (n)
			send_cmd(1'b1, 16'($urandom), $urandom);
	endtask

	task automatic load_program(input logic [15:0] base);
		foreach (prog[i])
			send_cmd(1'b0, base + 16'(i), prog[i]);
	endtask

	// Source operand: immediates of all sizes, register names, and words that
	// look like register names but read zero
	function automatic logic [31:0] pick_src();
		case ($urandom_range(0, 7))
			0, 1: return $urandom;
			2: return $urandom_range(0, 63);
			3: return wvm_pkg::RC_A + $urandom_range(0, 4);
			4: return 32'h20000000 | $urandom_range(6, 32'h0FFFFFFF);
			5: return 32'hFFFFFFFF;
			6: return 32'h0;
			default: return (32'h2 << (4 * $urandom_range(0, 7))) | ($urandom & 32'h000000FF);
		endcase
	endfunction

	// Compare operands: small values so both outcomes show up often
	function automatic logic [31:0] pick_cmp();
		if ($urandom_range(0, 1))
			return $urandom_range(0, 3);
		return pick_src();
	endfunction

	// Jump target word: leading digit 1 keeps it an immediate, low half is the address
	function automatic logic [31:0] target_word(input logic [15:0] addr);
		return 32'h10000000 | {16'h0, addr};
	endfunction

	task automatic add_op(input logic [31:0] op);
		starts.push_back(prog.size());
		prog.push_back(op);
		case (op)
			wvm_pkg::OP_MOVE: begin
				prog.push_back(pick_src());
				prog.push_back(($urandom_range(0, 4) != 0)
					? wvm_pkg::RC_A + $urandom_range(0, 4) : $urandom);
			end
			wvm_pkg::OP_ADD, wvm_pkg::OP_SUB, wvm_pkg::OP_MUL: begin
				prog.push_back(pick_src());
				prog.push_back(pick_src());
			end
			wvm_pkg::OP_DIV: begin
				// Divisor stays a nonzero immediate so the run never stops early
				prog.push_back(pick_src());
				prog.push_back($urandom_range(0, 1) ? (32'h10000000 | ($urandom & 32'h0FFFFFFF))
					: $urandom_range(3, 31));
			end
			wvm_pkg::OP_PUSH, wvm_pkg::OP_PHEX, wvm_pkg::OP_PCHR: prog.push_back(pick_src());
			wvm_pkg::OP_POP, wvm_pkg::OP_SLEEP: prog.push_back($urandom);
			wvm_pkg::OP_JMP: begin
				jump_slots.push_back(prog.size());
				prog.push_back('0);
			end
			wvm_pkg::OP_JEQ, wvm_pkg::OP_JNE, wvm_pkg::OP_JGT,
			wvm_pkg::OP_JLT, wvm_pkg::OP_JGE, wvm_pkg::OP_JLE: begin
				prog.push_back(pick_cmp());
				prog.push_back(pick_cmp());
				jump_slots.push_back(prog.size());
				prog.push_back('0);
			end
			default: ;
		endcase
	endtask

	function automatic logic [31:0] random_op();
		case ($urandom_range(0, 19))
			0, 1: return wvm_pkg::OP_MOVE;
			2, 3, 4: return wvm_pkg::OP_PUSH;
			5: return wvm_pkg::OP_POP;
			6: return wvm_pkg::OP_ADD;
			7: return wvm_pkg::OP_SUB;
			8: return wvm_pkg::OP_MUL;
			9: return wvm_pkg::OP_DIV;
			10: return wvm_pkg::OP_PHEX;
			11: return wvm_pkg::OP_PCHR;
			12: return wvm_pkg::OP_SLEEP;
			13: return wvm_pkg::OP_JMP;
			14, 15, 16: return wvm_pkg::OP_JEQ + $urandom_range(0, 5);
			17: return wvm_pkg::OP_RESET + 32'd1;
			18: return wvm_pkg::OP_SLEEP + 32'd1;
			default: return 32'h10000015 + $urandom_range(0, 32'h00FFFFEA);
		endcase
	endfunction

	initial begin
		logic [15:0] pc_now, base;
		int n_ops;
		logic [31:0] dir_ops [19];
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = 1'b0;
		load_address = '0;
		load_word = '0;
		sent = 0;
		burst_left = 0;
		writes_done = 0;
		steps_done = 0;
		hold_req = 1'b0;
		hold_taken = 1'b0;
		dir_ops = '{wvm_pkg::OP_MOVE, wvm_pkg::OP_PUSH, wvm_pkg::OP_POP, wvm_pkg::OP_ADD,
			wvm_pkg::OP_SUB, wvm_pkg::OP_MUL, wvm_pkg::OP_DIV, wvm_pkg::OP_PHEX,
			wvm_pkg::OP_PCHR, wvm_pkg::OP_SLEEP, wvm_pkg::OP_RESET + 32'd1, wvm_pkg::OP_JMP,
			wvm_pkg::OP_JEQ, wvm_pkg::OP_JNE, wvm_pkg::OP_JGT, wvm_pkg::OP_JLT,
			wvm_pkg::OP_JGE, wvm_pkg::OP_JLE, wvm_pkg::OP_RESET};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extreme addresses and words, then every opcode but halt once, plus an
		// unknown one, in a straight line. Each jump aims at the next instruction, so taken and
		// not-taken paths both land there; the reset at the end loops to 0.
		send_cmd(1'b0, 16'hFFFF, 32'hFFFFFFFF);
		send_cmd(1'b0, 16'hAAAA, 32'h55555555);
		send_cmd(1'b0, 16'h5555, 32'hAAAAAAAA);
		prog.delete();
		starts.delete();
		jump_slots.delete();
		foreach (dir_ops[k])
			add_op(dir_ops[k]);
		foreach (jump_slots[j])
			prog[jump_slots[j]] = target_word(16'(jump_slots[j]));
		load_program(16'h0000);
		run_steps(starts.size() + 3);

		// Random programs. Each one: drain, learn the PC, maybe scatter some
		// stray writes, usually jump from the PC to a fresh base through a two-word
		// trampoline, load the program there and step it. Every jump stays inside
		// the program and the last instruction loops back to its start.
		while (sent < TARGET_ITEMS) begin
			drain();
			pc_now = last_pc;
			// Start the long output hold while the sender keeps offering items
			if (!hold_req && sent > 200)
				hold_req = 1'b1;
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 4))
					send_cmd(1'b0, 16'($urandom), $urandom);
			case ($urandom_range(0, 9))
				0: base = 16'hFFF0 + 16'($urandom_range(0, 15));
				1: base = 16'($urandom_range(0, 40));
				default: base = 16'($urandom_range(400, 65535));
			endcase
			prog.delete();
			starts.delete();
			jump_slots.delete();
			n_ops = $urandom_range(3, 10);
			repeat (n_ops)
				add_op(random_op());
			add_op(wvm_pkg::OP_JMP);
			for (int j = 0; j < jump_slots.size() - 1; j++)
				prog[jump_slots[j]] = target_word(base - 16'd1
					+ 16'(starts[$urandom_range(0, starts.size() - 1)]));
			prog[jump_slots[jump_slots.size() - 1]] = target_word(base - 16'd1);
			// Now and then skip the trampoline: the old loop keeps running
			if ($urandom_range(0, 7) != 0) begin
				send_cmd(1'b0, pc_now, wvm_pkg::OP_JMP);
				send_cmd(1'b0, pc_now + 16'd1, target_word(base - 16'd1));
				run_steps(1);
			end
			load_program(base);
			run_steps($urandom_range(n_ops, 3 * n_ops));
		end

		// Stop the machine at the very end: halt or divide by zero, then show
		// that steps do nothing and writes still go through
		drain();
		pc_now = last_pc;
		ended_on_halt = ($urandom_range(0, 1) == 1);
		if (ended_on_halt) begin
			send_cmd(1'b0, pc_now, wvm_pkg::OP_HALT);
		end else begin
			send_cmd(1'b0, pc_now, wvm_pkg::OP_DIV);
			send_cmd(1'b0, pc_now + 16'd1, pick_src());
			send_cmd(1'b0, pc_now + 16'd2, 32'h0);
		end
		run_steps(2);
		send_cmd(1'b0, 16'($urandom), $urandom);
		run_steps(1);

		in_valid <= 1'b0;
		drain();
		repeat (60) @(posedge clk);
		$display("covered %0d program writes and %0d execute steps, %0d results compared,",
			writes_done, steps_done, got);
		$display("random programs at random bases with a long output hold, stopped by %s",
			ended_on_halt ? "halt" : "divide by zero");
		if (failures == 0) begin
			$display("word_vm_instruction_step_top_test: done, clean");
		end else begin
			$display("word_vm_instruction_step_top_test: done, errors");
		end
		$finish;
	end
endmodule
